// File: hw/rtl/pwsfd_pkg.sv
// ----------------------------------------------------------------------------
// pwsfd_pkg
// Shared types and constants of the pulse width sensor frame decoder.
// ----------------------------------------------------------------------------
package pwsfd_pkg;

  localparam int unsigned FRAME_BITS = 40;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // event kinds
  localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EDGE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_BUSY     = 3'd0;
  localparam logic [STAT_W-1:0] ST_OK       = 3'd1;
  localparam logic [STAT_W-1:0] ST_CSUM_BAD = 3'd2;
  localparam logic [STAT_W-1:0] ST_TIMING   = 3'd3;
  localparam logic [STAT_W-1:0] ST_TIMEOUT  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRE_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = 2'd3;

  localparam logic [CFG_W-1:0] PRE_BIT_RST = 8'd50;
  localparam logic [CFG_W-1:0] ZERO_RST    = 8'd28;
  localparam logic [CFG_W-1:0] ONE_RST     = 8'd70;
  localparam logic [CFG_W-1:0] MARGIN_RST  = 8'd10;

  typedef struct packed {
    logic [CFG_W-1:0] pre_bit_delay_us;
    logic [CFG_W-1:0] zero_max_us;
    logic [CFG_W-1:0] one_max_us;
    logic [CFG_W-1:0] margin_us;
  } cfg_t;

  typedef struct packed {
    logic is_one;
    logic err;
  } bit_class_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              frame_done;
    logic [7:0]        humidity_int;
    logic [7:0]        humidity_frac;
    logic [7:0]        temp_int;
    logic [7:0]        temperature_frac;
    logic [7:0]        checksum_byte;
  } result_t;

endpackage

// File: hw/rtl/pwsfd_bit_class.sv
// ----------------------------------------------------------------------------
// pwsfd_bit_class
// Measures the high time of one bit and classifies it as zero, one or error.
// ----------------------------------------------------------------------------
module pwsfd_bit_class (
  input  logic [pwsfd_pkg::TIME_W-1:0] edge_time_us,
  input  logic [pwsfd_pkg::TIME_W-1:0] last_edge_time,
  input  pwsfd_pkg::cfg_t              cfg,
  output pwsfd_pkg::bit_class_t        cls
);

  logic [pwsfd_pkg::TIME_W-1:0] high_time;
  logic [pwsfd_pkg::CFG_W:0]    zero_lim;
  logic [pwsfd_pkg::CFG_W:0]    one_lim;
  logic                         le_zero;
  logic                         le_one;

  // interval minus pre-bit low time, wraps modulo 2^32, read as signed
  assign high_time = edge_time_us - last_edge_time
                     - {{(pwsfd_pkg::TIME_W-pwsfd_pkg::CFG_W){1'b0}}, cfg.pre_bit_delay_us};

  assign zero_lim = {1'b0, cfg.zero_max_us} + {1'b0, cfg.margin_us};
  assign one_lim  = {1'b0, cfg.one_max_us} + {1'b0, cfg.margin_us};

  assign le_zero = $signed(high_time) <=
                   $signed({{(pwsfd_pkg::TIME_W-pwsfd_pkg::CFG_W-1){1'b0}}, zero_lim});
  assign le_one  = $signed(high_time) <=
                   $signed({{(pwsfd_pkg::TIME_W-pwsfd_pkg::CFG_W-1){1'b0}}, one_lim});

  assign cls.is_one = !le_zero && le_one;
  assign cls.err    = !le_zero && !le_one;

endmodule

// File: hw/rtl/pwsfd_core.sv
// ----------------------------------------------------------------------------
// pwsfd_core
// Frame state and per-event step: phase, bit count, baseline time, shifter.
// ----------------------------------------------------------------------------
module pwsfd_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [pwsfd_pkg::ACT_W-1:0]    action,
  input  logic [pwsfd_pkg::TIME_W-1:0]   edge_time_us,
  input  logic                           line_level,
  input  pwsfd_pkg::cfg_t                cfg,
  output pwsfd_pkg::result_t             res
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ACK1 = 2'd1;
  localparam logic [1:0] PH_ACK2 = 2'd2;
  localparam logic [1:0] PH_BITS = 2'd3;

  localparam int unsigned SHIFT_W = pwsfd_pkg::FRAME_BITS;
  localparam logic [pwsfd_pkg::CNT_W-1:0] LAST_CNT = pwsfd_pkg::CNT_W'(pwsfd_pkg::FRAME_BITS);

  logic [1:0]                     phase_r, phase_nxt;
  logic [pwsfd_pkg::CNT_W-1:0]    bit_count_r, bit_count_nxt;
  logic [pwsfd_pkg::TIME_W-1:0]   last_edge_r, last_edge_nxt;
  logic [SHIFT_W-1:0]             shift_r, shift_nxt;

  pwsfd_pkg::bit_class_t          cls;
  logic [SHIFT_W-1:0]             shift_bit;
  logic [SHIFT_W-1:0]             shift_done;
  logic [pwsfd_pkg::CNT_W-1:0]    count_inc;
  logic [7:0]                     byte_sum;

  pwsfd_bit_class u_cls (
    .edge_time_us   (edge_time_us),
    .last_edge_time (last_edge_r),
    .cfg            (cfg),
    .cls            (cls)
  );

  assign shift_bit  = {shift_r[SHIFT_W-2:0], cls.is_one};
  assign shift_done = {shift_bit[SHIFT_W-2:0], line_level};
  assign count_inc  = bit_count_r + 1'b1;
  assign byte_sum   = shift_done[39:32] + shift_done[31:24] + shift_done[23:16]
                      + shift_done[15:8];

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    last_edge_nxt = last_edge_r;
    shift_nxt     = shift_r;
    res           = '0;
    if (step) begin
      unique case (action)
        pwsfd_pkg::ACT_START: begin
          phase_nxt     = PH_ACK1;
          bit_count_nxt = '0;
          last_edge_nxt = '0;
          shift_nxt     = '0;
        end
        pwsfd_pkg::ACT_TIMEOUT: begin
          if (phase_r != PH_IDLE) begin
            phase_nxt      = PH_IDLE;
            res.status     = pwsfd_pkg::ST_TIMEOUT;
            res.frame_done = 1'b1;
          end
        end
        pwsfd_pkg::ACT_EDGE: begin
          unique case (phase_r)
            PH_ACK1: phase_nxt = PH_ACK2;
            PH_ACK2: phase_nxt = PH_BITS;
            PH_BITS: begin
              last_edge_nxt = edge_time_us;
              if (bit_count_r == '0) begin
                bit_count_nxt = 6'd1;
              end else if (cls.err) begin
                // timing error ends the frame, even on the final edge
                phase_nxt      = PH_IDLE;
                res.status     = pwsfd_pkg::ST_TIMING;
                res.frame_done = 1'b1;
              end else begin
                bit_count_nxt = count_inc;
                shift_nxt     = shift_bit;
                if (count_inc >= LAST_CNT) begin
                  // last bit comes from the sampled line level
                  shift_nxt            = shift_done;
                  phase_nxt            = PH_IDLE;
                  res.status           = (byte_sum == shift_done[7:0]) ?
                                         pwsfd_pkg::ST_OK : pwsfd_pkg::ST_CSUM_BAD;
                  res.frame_done       = 1'b1;
                  res.humidity_int     = shift_done[39:32];
                  res.humidity_frac    = shift_done[31:24];
                  res.temp_int         = shift_done[23:16];
                  res.temperature_frac = shift_done[15:8];
                  res.checksum_byte    = shift_done[7:0];
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= '0;
      last_edge_r <= '0;
      shift_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      last_edge_r <= last_edge_nxt;
      shift_r     <= shift_nxt;
    end
  end

endmodule

// File: hw/rtl/pulse_width_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// pulse_width_sensor_frame_decoder
// Decodes one read frame of a single-wire temperature and humidity sensor.
// ----------------------------------------------------------------------------
// Every input transfer is one event (start, rising edge, timeout) and yields
// exactly one output transfer. Events pass an input register, one step of
// combinational decode against the frame state, and an output register, so
// a result is offered once the input register and then the output register
// have held it; a new event is taken every cycle; throughput drops only while
// out_tready is low and both registers are full. out_tlast marks the event
// that ended a frame, out_tuser carries its status, and the five received
// bytes are nonzero only for status frame ok or checksum bad. Configuration
// writes are taken at any time but must only be issued while no event is in
// flight.
// ----------------------------------------------------------------------------
module pulse_width_sensor_frame_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  // input events
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pwsfd_pkg::IN_DATA_W-1:0]    in_tdata,   // edge_time_us, line_level, zero pad
  input  logic [pwsfd_pkg::ACT_W-1:0]        in_tuser,   // action
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pwsfd_pkg::OUT_DATA_W-1:0]   out_tdata,  // humidity_int, humidity_frac,
                                                         // temp_int, temperature_frac,
                                                         // checksum_byte
  output logic [pwsfd_pkg::STAT_W-1:0]       out_tuser,  // status
  output logic                               out_tlast,  // frame_done
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwsfd_pkg::CFG_W-1:0]        cfg_data
);

  logic                               in_valid_r;
  logic [pwsfd_pkg::ACT_W-1:0]        act_r;
  logic [pwsfd_pkg::TIME_W-1:0]       time_r;
  logic                               level_r;
  logic                               advance;
  logic                               out_valid_r;
  pwsfd_pkg::result_t                 res;
  pwsfd_pkg::result_t                 res_r;
  pwsfd_pkg::cfg_t                    cfg_r;

  // step the decoder when an event is held and the output slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // input register: hold the event until the decode step takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r   <= in_tuser;
      time_r  <= in_tdata[pwsfd_pkg::TIME_W-1:0];
      level_r <= in_tdata[pwsfd_pkg::TIME_W];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_bit_delay_us <= pwsfd_pkg::PRE_BIT_RST;
      cfg_r.zero_max_us      <= pwsfd_pkg::ZERO_RST;
      cfg_r.one_max_us       <= pwsfd_pkg::ONE_RST;
      cfg_r.margin_us        <= pwsfd_pkg::MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwsfd_pkg::REG_PRE_BIT: cfg_r.pre_bit_delay_us <= cfg_data;
        pwsfd_pkg::REG_ZERO:    cfg_r.zero_max_us      <= cfg_data;
        pwsfd_pkg::REG_ONE:     cfg_r.one_max_us       <= cfg_data;
        pwsfd_pkg::REG_MARGIN:  cfg_r.margin_us        <= cfg_data;
        default: ;
      endcase
    end
  end

  pwsfd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .action       (act_r),
    .edge_time_us (time_r),
    .line_level   (level_r),
    .cfg          (cfg_r),
    .res          (res)
  );

  // output register: hold the result until the sink takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.frame_done;
  assign out_tdata  = {res_r.checksum_byte, res_r.temperature_frac, res_r.temp_int,
                       res_r.humidity_frac, res_r.humidity_int};

endmodule

// File: hw/rtl/pwsfd_checker.sv
// ----------------------------------------------------------------------------
// pwsfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pwsfd_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [pwsfd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic [pwsfd_pkg::STAT_W-1:0]       out_tuser,
  input  logic                               out_tlast
);

  // no result may appear right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // end of frame and a nonzero status go together
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser != pwsfd_pkg::ST_BUSY)))
    else $error("frame end flag does not match status");

  // bytes are reported only with a completed frame
  a_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != pwsfd_pkg::ST_OK && out_tuser != pwsfd_pkg::ST_CSUM_BAD
      |-> out_tdata == '0)
    else $error("data bytes outside a completed frame");

endmodule

bind pulse_width_sensor_frame_decoder pwsfd_checker u_pwsfd_checker (.*);
